// ===== sv/smu_pkg.sv =====
// ----------------------------------------------------------------------------
// smu_pkg
// Shared types and codes for the sorted merge update unit.
// ----------------------------------------------------------------------------
package smu_pkg;

   localparam int FIELD_BITS = 32;

   typedef logic [FIELD_BITS-1:0] field_type;

   // input action codes
   localparam logic [1:0] ACT_BASE     = 2'd0;
   localparam logic [1:0] ACT_UPDATE   = 2'd1;
   localparam logic [1:0] ACT_BASE_END = 2'd2;
   localparam logic [1:0] ACT_UPD_END  = 2'd3;

   // update op codes
   localparam logic [1:0] OP_INVALID = 2'd0;
   localparam logic [1:0] OP_INSERT  = 2'd1;
   localparam logic [1:0] OP_REPLACE = 2'd2;
   localparam logic [1:0] OP_DELETE  = 2'd3;

   // error codes
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_BAD_OP  = 2'd1;
   localparam logic [1:0] ERR_REFUSED = 2'd2;

   // emitted record source
   localparam logic SRC_BASE   = 1'b0;
   localparam logic SRC_UPDATE = 1'b1;

   typedef struct packed {
      logic [1:0] action;
      field_type  rec_key;
      logic [1:0] update_op;
      field_type  rec_payload;
   } item_type;

   typedef struct packed {
      logic       emit_valid;
      logic       emit_source;
      field_type  out_key;
      field_type  out_payload;
      logic       want_base;
      logic       want_update;
      logic [1:0] error_code;
      logic       done_res;
   } result_type;

endpackage

// ===== sv/smu_merge_core.sv =====
// ----------------------------------------------------------------------------
// smu_merge_core
// Head slots of both streams and the combinational intake and merge decision.
// ----------------------------------------------------------------------------
module smu_merge_core #(
   parameter int KEY_W = 32,
   parameter int PAY_W = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  smu_pkg::item_type   item,
   output smu_pkg::result_type result
);

   logic             base_held_ff, base_held_in;
   logic [KEY_W-1:0] base_key_ff, base_key_in;
   logic [PAY_W-1:0] base_pay_ff, base_pay_in;
   logic             base_fin_ff, base_fin_in;
   logic             upd_held_ff, upd_held_in;
   logic [KEY_W-1:0] upd_key_ff, upd_key_in;
   logic [1:0]       upd_op_ff, upd_op_in;
   logic [PAY_W-1:0] upd_pay_ff, upd_pay_in;
   logic             upd_fin_ff, upd_fin_in;

   logic             refused;
   logic             bad_op;
   logic             emit;
   logic             src;
   logic [KEY_W-1:0] sel_key;
   logic [PAY_W-1:0] sel_pay;
   logic             do_base;
   logic             do_upd;
   logic             same_key;

   always_comb begin
      base_held_in = base_held_ff;
      base_key_in  = base_key_ff;
      base_pay_in  = base_pay_ff;
      base_fin_in  = base_fin_ff;
      upd_held_in  = upd_held_ff;
      upd_key_in   = upd_key_ff;
      upd_op_in    = upd_op_ff;
      upd_pay_in   = upd_pay_ff;
      upd_fin_in   = upd_fin_ff;
      refused      = 1'b0;
      bad_op       = 1'b0;
      emit         = 1'b0;
      src          = smu_pkg::SRC_BASE;
      do_base      = 1'b0;
      do_upd       = 1'b0;
      same_key     = 1'b0;

      // intake
      case (item.action)
         smu_pkg::ACT_BASE: begin
            if (base_held_ff || base_fin_ff) begin
               refused = 1'b1;
            end else begin
               base_held_in = 1'b1;
               base_key_in  = item.rec_key[KEY_W-1:0];
               base_pay_in  = item.rec_payload[PAY_W-1:0];
            end
         end
         smu_pkg::ACT_UPDATE: begin
            if (upd_held_ff || upd_fin_ff) begin
               refused = 1'b1;
            end else begin
               upd_held_in = 1'b1;
               upd_key_in  = item.rec_key[KEY_W-1:0];
               upd_op_in   = item.update_op;
               upd_pay_in  = item.rec_payload[PAY_W-1:0];
            end
         end
         smu_pkg::ACT_BASE_END: begin
            if (base_fin_ff) refused = 1'b1;
            else             base_fin_in = 1'b1;
         end
         default: begin
            if (upd_fin_ff) refused = 1'b1;
            else            upd_fin_in = 1'b1;
         end
      endcase

      // merge decision on the updated heads
      if (base_held_in && upd_held_in) begin
         if (base_key_in < upd_key_in) do_base = 1'b1;
         else                          do_upd  = 1'b1;
         same_key = (base_key_in == upd_key_in);
      end else if (base_held_in && upd_fin_in) begin
         do_base = 1'b1;
      end else if (upd_held_in && base_fin_in) begin
         do_upd = 1'b1;
      end

      sel_key = do_base ? base_key_in : upd_key_in;
      sel_pay = do_base ? base_pay_in : upd_pay_in;

      if (do_base) begin
         emit         = 1'b1;
         src          = smu_pkg::SRC_BASE;
         base_held_in = 1'b0;
      end else if (do_upd) begin
         src         = smu_pkg::SRC_UPDATE;
         upd_held_in = 1'b0;
         case (upd_op_in)
            smu_pkg::OP_INSERT: begin
               emit = 1'b1;
            end
            smu_pkg::OP_REPLACE: begin
               emit = 1'b1;
               if (same_key) base_held_in = 1'b0;
            end
            smu_pkg::OP_DELETE: begin
               if (same_key) base_held_in = 1'b0;
            end
            default: begin
               bad_op = 1'b1;
            end
         endcase
      end

      result.emit_valid  = emit;
      result.emit_source = emit ? src : smu_pkg::SRC_BASE;
      result.out_key     = emit ? smu_pkg::field_type'(sel_key) : '0;
      result.out_payload = emit ? smu_pkg::field_type'(sel_pay) : '0;
      result.want_base   = !base_held_in && !base_fin_in;
      result.want_update = !upd_held_in && !upd_fin_in;
      result.error_code  = refused ? smu_pkg::ERR_REFUSED :
                           (bad_op ? smu_pkg::ERR_BAD_OP : smu_pkg::ERR_NONE);
      result.done_res    = base_fin_in && upd_fin_in && !base_held_in && !upd_held_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_held_ff <= 1'b0;
         base_key_ff  <= '0;
         base_pay_ff  <= '0;
         base_fin_ff  <= 1'b0;
         upd_held_ff  <= 1'b0;
         upd_key_ff   <= '0;
         upd_op_ff    <= smu_pkg::OP_INVALID;
         upd_pay_ff   <= '0;
         upd_fin_ff   <= 1'b0;
      end else if (step_en) begin
         base_held_ff <= base_held_in;
         base_key_ff  <= base_key_in;
         base_pay_ff  <= base_pay_in;
         base_fin_ff  <= base_fin_in;
         upd_held_ff  <= upd_held_in;
         upd_key_ff   <= upd_key_in;
         upd_op_ff    <= upd_op_in;
         upd_pay_ff   <= upd_pay_in;
         upd_fin_ff   <= upd_fin_in;
      end
   end

endmodule

// ===== sv/smu_out_queue.sv =====
// ----------------------------------------------------------------------------
// smu_out_queue
// Two-entry result queue; decouples result stalls from the intake side.
// ----------------------------------------------------------------------------
module smu_out_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  smu_pkg::result_type push_data,
   output logic                room,
   output logic                out_valid,
   input  logic                out_ready,
   output smu_pkg::result_type out_data
);

   smu_pkg::result_type entry_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;
   logic                pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != 2'd0);
   assign room      = (count_ff != 2'd2);
   assign out_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/sorted_merge_update_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_merge_update_unit
// Merges a key-sorted base stream with a key-sorted update stream, one head
// slot per stream, and applies insert, replace and delete updates.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | contents
//  req_    | in        | req_valid/req_ready  | action, key, op, payload
//  rsp_    | out       | rsp_valid/rsp_ready  | one result per request
//
//  One request per cycle sustained while the result queue has room; rsp_valid
//  rises once a request has passed the input register and the merge logic
//  into the result queue; a full queue holds it in the input register.
//  The merge step is a combinational key compare and slot update.
//  A two-entry result queue absorbs rsp_ready stalls; req_ready drops only
//  once the queue is full and the input register is occupied.
//  Synchronous reset empties both head slots and clears the end marks.
// ----------------------------------------------------------------------------
module sorted_merge_update_unit #(
   parameter int KEY_BITS     = 32,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_rec_key,
   input  logic [1:0]  req_update_op,
   input  logic [31:0] req_rec_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_emit_valid,
   output logic        rsp_emit_source,
   output logic [31:0] rsp_out_key,
   output logic [31:0] rsp_out_payload,
   output logic        rsp_want_base,
   output logic        rsp_want_update,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_done_res
);

   localparam int KEY_W = (KEY_BITS < smu_pkg::FIELD_BITS) ? KEY_BITS : smu_pkg::FIELD_BITS;
   localparam int PAY_W = (PAYLOAD_BITS < smu_pkg::FIELD_BITS) ?
                          PAYLOAD_BITS : smu_pkg::FIELD_BITS;

   logic                in_valid_ff, in_valid_in;
   smu_pkg::item_type   in_item_ff;
   logic                req_xfer;
   logic                advance;
   logic                q_room;
   smu_pkg::result_type step_result;
   smu_pkg::result_type rsp_data;

   assign req_ready = !in_valid_ff || q_room;
   assign req_xfer  = req_valid && req_ready;
   assign advance   = in_valid_ff && q_room;

   always_comb begin
      if (req_xfer)     in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      else              in_valid_in = in_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff.action      <= req_action;
         in_item_ff.rec_key     <= req_rec_key;
         in_item_ff.update_op   <= req_update_op;
         in_item_ff.rec_payload <= req_rec_payload;
      end
   end

   smu_merge_core #(
      .KEY_W (KEY_W),
      .PAY_W (PAY_W)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .result  (step_result)
   );

   smu_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .push_data (step_result),
      .room      (q_room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_emit_valid  = rsp_data.emit_valid;
   assign rsp_emit_source = rsp_data.emit_source;
   assign rsp_out_key     = rsp_data.out_key;
   assign rsp_out_payload = rsp_data.out_payload;
   assign rsp_want_base   = rsp_data.want_base;
   assign rsp_want_update = rsp_data.want_update;
   assign rsp_error_code  = rsp_data.error_code;
   assign rsp_done_res    = rsp_data.done_res;

endmodule

// ===== sv/smu_checker.sv =====
// ----------------------------------------------------------------------------
// smu_checker
// Port-level checks on the result channel of the merge update unit.
// ----------------------------------------------------------------------------
module smu_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_emit_valid,
   input logic        rsp_emit_source,
   input logic [31:0] rsp_out_key,
   input logic [31:0] rsp_out_payload,
   input logic        rsp_want_base,
   input logic        rsp_want_update,
   input logic [1:0]  rsp_error_code,
   input logic        rsp_done_res
);

   // stalled transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_key)
         && $stable(rsp_out_payload) && $stable(rsp_error_code))
      else $error("result changed while stalled");

   a_no_emit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_emit_valid |-> rsp_out_key == 32'd0
         && rsp_out_payload == 32'd0 && rsp_emit_source == 1'b0)
      else $error("non-emitting result carries record data");

   a_done_no_want: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_want_base && !rsp_want_update)
      else $error("done while a stream still wants input");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_error_code != 2'd3)
      else $error("undefined error code");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind sorted_merge_update_unit smu_checker u_smu_checker (.*);

// ===== verif/sorted_merge_update_unit_test.sv =====
// ----------------------------------------------------------------------------
// sorted_merge_update_unit_test
// Self-checking bench for the sorted merge update unit. A table of directed
// transactions covers key and payload extremes, every update kind, refusals,
// end marks and the drain after a stream ends. Between the opening and the
// closing part of the table, key-sorted base and update streams with random
// payloads and occasional noise are merged. Every response is compared field
// by field with a typed expected result or a behavioural merge predictor kept
// inside the bench, while both handshakes are throttled at random.
// ----------------------------------------------------------------------------
module sorted_merge_update_unit_test;

   localparam int IDLE_PCT     = 37;
   localparam int RANDOM_ITEMS = 1820;
   localparam int CALM_FIRST   = 700;
   localparam int CALM_LAST    = 1000;
   localparam int NOISE_PCT    = 15;
   localparam int OPENING_ROWS = 12;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 200000;

   localparam logic TYPED     = 1'b1;
   localparam logic PREDICTED = 1'b0;
   localparam smu_pkg::result_type NO_RES = '0;

   typedef struct packed {
      smu_pkg::item_type   stim;
      logic                fixed;
      smu_pkg::result_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action = smu_pkg::ACT_BASE;
   logic [31:0] req_rec_key = '0;
   logic [1:0]  req_update_op = smu_pkg::OP_INVALID;
   logic [31:0] req_rec_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_emit_valid;
   logic        rsp_emit_source;
   logic [31:0] rsp_out_key;
   logic [31:0] rsp_out_payload;
   logic        rsp_want_base;
   logic        rsp_want_update;
   logic [1:0]  rsp_error_code;
   logic        rsp_done_res;

   // predictor state
   logic               base_held = 1'b0;
   logic               base_closed = 1'b0;
   smu_pkg::field_type base_key = '0;
   smu_pkg::field_type base_pay = '0;
   logic               upd_held = 1'b0;
   logic               upd_closed = 1'b0;
   smu_pkg::field_type upd_key = '0;
   logic [1:0]         upd_op = smu_pkg::OP_INVALID;
   smu_pkg::field_type upd_pay = '0;

   smu_pkg::field_type  key_cursor = 32'd16;
   smu_pkg::result_type pending_results[$];
   int                  idle_pct = IDLE_PCT;
   int                  cycle_count = 0;
   int                  failures = 0;

   sorted_merge_update_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_rec_key     (req_rec_key),
      .req_update_op   (req_update_op),
      .req_rec_payload (req_rec_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_emit_valid  (rsp_emit_valid),
      .rsp_emit_source (rsp_emit_source),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_payload (rsp_out_payload),
      .rsp_want_base   (rsp_want_base),
      .rsp_want_update (rsp_want_update),
      .rsp_error_code  (rsp_error_code),
      .rsp_done_res    (rsp_done_res)
   );

   always #5 clock = ~clock;

   task automatic note_failure(input string msg);
      $display("ERROR cycle %0d: %s", cycle_count, msg);
      failures++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] exp);
      if (got !== exp)
         note_failure($sformatf("%s got %h expected %h", name, got, exp));
   endtask

   function automatic smu_pkg::result_type idle_res(input logic wb, input logic wu,
                                                    input logic [1:0] err,
                                                    input logic dn);
      smu_pkg::result_type r;
      r = '0;
      r.want_base   = wb;
      r.want_update = wu;
      r.error_code  = err;
      r.done_res    = dn;
      return r;
   endfunction

   function automatic smu_pkg::result_type emit_res(input logic src,
                                                    input smu_pkg::field_type k,
                                                    input smu_pkg::field_type p,
                                                    input logic wb,
                                                    input logic wu);
      smu_pkg::result_type r;
      r = idle_res(wb, wu, smu_pkg::ERR_NONE, 1'b0);
      r.emit_valid  = 1'b1;
      r.emit_source = src;
      r.out_key     = k;
      r.out_payload = p;
      return r;
   endfunction

   // one merge step: take in the transaction, then at most one decision
   function automatic smu_pkg::result_type merge_step(input smu_pkg::item_type it);
      smu_pkg::result_type r;
      logic                refused;
      logic                bad_op;
      logic                emit;
      logic                src;
      logic                same;
      smu_pkg::field_type  k;
      smu_pkg::field_type  p;
      refused = 1'b0;
      bad_op  = 1'b0;
      emit    = 1'b0;
      src     = smu_pkg::SRC_BASE;
      k       = '0;
      p       = '0;
      case (it.action)
         smu_pkg::ACT_BASE: begin
            if (base_held || base_closed) begin
               refused = 1'b1;
            end else begin
               base_held = 1'b1;
               base_key  = it.rec_key;
               base_pay  = it.rec_payload;
            end
         end
         smu_pkg::ACT_UPDATE: begin
            if (upd_held || upd_closed) begin
               refused = 1'b1;
            end else begin
               upd_held = 1'b1;
               upd_key  = it.rec_key;
               upd_op   = it.update_op;
               upd_pay  = it.rec_payload;
            end
         end
         smu_pkg::ACT_BASE_END: begin
            if (base_closed) refused = 1'b1;
            else base_closed = 1'b1;
         end
         default: begin
            if (upd_closed) refused = 1'b1;
            else upd_closed = 1'b1;
         end
      endcase
      if (base_held && (upd_held ? base_key < upd_key : upd_closed)) begin
         emit      = 1'b1;
         k         = base_key;
         p         = base_pay;
         base_held = 1'b0;
      end else if (upd_held && (base_held || base_closed)) begin
         same = base_held && base_key == upd_key;
         src  = smu_pkg::SRC_UPDATE;
         k    = upd_key;
         p    = upd_pay;
         case (upd_op)
            smu_pkg::OP_INSERT: emit = 1'b1;
            smu_pkg::OP_REPLACE: begin
               emit = 1'b1;
               if (same) base_held = 1'b0;
            end
            smu_pkg::OP_DELETE: if (same) base_held = 1'b0;
            default: bad_op = 1'b1;
         endcase
         upd_held = 1'b0;
      end
      if (emit) r = emit_res(src, k, p, 1'b0, 1'b0);
      else r = '0;
      r.want_base   = !base_held && !base_closed;
      r.want_update = !upd_held && !upd_closed;
      r.error_code  = refused ? smu_pkg::ERR_REFUSED :
                      (bad_op ? smu_pkg::ERR_BAD_OP : smu_pkg::ERR_NONE);
      r.done_res    = base_closed && upd_closed && !base_held && !upd_held;
      return r;
   endfunction

   // mostly key-sorted records; noise hits a full slot or steps a key back
   function automatic smu_pkg::item_type next_record();
      smu_pkg::item_type it;
      it.rec_payload = $urandom;
      it.update_op   = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 99) < NOISE_PCT) begin
         if (base_held) it.action = smu_pkg::ACT_BASE;
         else if (upd_held) it.action = smu_pkg::ACT_UPDATE;
         else it.action = $urandom_range(0, 1) ? smu_pkg::ACT_BASE : smu_pkg::ACT_UPDATE;
         if (base_held || upd_held) it.rec_key = $urandom;
         else it.rec_key = key_cursor - $urandom_range(0, 7);
      end else if (!base_held && (upd_held || $urandom_range(0, 1))) begin
         key_cursor += $urandom_range(0, 3);
         it.action  = smu_pkg::ACT_BASE;
         it.rec_key = key_cursor;
      end else begin
         it.action = smu_pkg::ACT_UPDATE;
         if (base_held && $urandom_range(0, 2) == 0) begin
            it.rec_key = base_key;
         end else begin
            key_cursor += $urandom_range(0, 3);
            it.rec_key = key_cursor;
         end
         if ($urandom_range(0, 19) == 0) it.update_op = smu_pkg::OP_INVALID;
         else it.update_op = 2'($urandom_range(smu_pkg::OP_INSERT, smu_pkg::OP_DELETE));
      end
      return it;
   endfunction

   // entered and left at a falling edge
   task automatic send_item(input smu_pkg::item_type it, input logic fixed,
                            input smu_pkg::result_type want);
      smu_pkg::result_type predicted;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_action      = it.action;
      req_rec_key     = it.rec_key;
      req_update_op   = it.update_op;
      req_rec_payload = it.rec_payload;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = merge_step(it);
      pending_results.insert(pending_results.size(), fixed ? want : predicted);
      @(negedge clock);
   endtask

   initial begin : stimulus
      stim_row_type      rows[$];
      smu_pkg::item_type it;
      rows.insert(rows.size(),
                  {{smu_pkg::ACT_BASE, 32'hFFFF_FFFF, smu_pkg::OP_DELETE, 32'h0},
                   TYPED, idle_res(1'b0, 1'b1, smu_pkg::ERR_NONE, 1'b0)});
      rows.insert(rows.size(),
                  {{smu_pkg::ACT_BASE, 32'd5, smu_pkg::OP_INSERT, 32'h1},
                   TYPED, idle_res(1'b0, 1'b1, smu_pkg::ERR_REFUSED, 1'b0)});
      rows.insert(rows.size(),
                  {{smu_pkg::ACT_UPDATE, 32'hFFFF_FFFF, smu_pkg::OP_INSERT, 32'hFFFF_FFFF},
                   TYPED, emit_res(smu_pkg::SRC_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   1'b0, 1'b1)});
      rows.insert(rows.size(),
                  {{smu_pkg::ACT_UPDATE, 32'hFFFF_FFFF, smu_pkg::OP_REPLACE, 32'hA5A5_A5A5},
                   TYPED, emit_res(smu_pkg::SRC_UPDATE, 32'hFFFF_FFFF, 32'hA5A5_A5A5,
                                   1'b1, 1'b1)});
      rows.insert(rows.size(),
                  {{smu_pkg::ACT_UPDATE, 32'h0, smu_pkg::OP_DELETE, 32'h5A5A_5A5A},
                   TYPED, idle_res(1'b1, 1'b0, smu_pkg::ERR_NONE, 1'b0)});
      rows.insert(rows.size(),
                  {{smu_pkg::ACT_UPDATE, 32'd7, smu_pkg::OP_INSERT, 32'h0},
                   TYPED, idle_res(1'b1, 1'b0, smu_pkg::ERR_REFUSED, 1'b0)});
      rows.insert(rows.size(),
                  {{smu_pkg::ACT_BASE, 32'h0, smu_pkg::OP_INVALID, 32'h1234_5678},
                   TYPED, idle_res(1'b1, 1'b1, smu_pkg::ERR_NONE, 1'b0)});
      rows.insert(rows.size(),
                  {{smu_pkg::ACT_BASE, 32'd10, smu_pkg::OP_REPLACE, 32'hAB},
                   TYPED, idle_res(1'b0, 1'b1, smu_pkg::ERR_NONE, 1'b0)});
      rows.insert(rows.size(),
                  {{smu_pkg::ACT_UPDATE, 32'd3, smu_pkg::OP_INVALID, 32'hFFFF_0000},
                   TYPED, idle_res(1'b0, 1'b1, smu_pkg::ERR_BAD_OP, 1'b0)});
      rows.insert(rows.size(),
                  {{smu_pkg::ACT_UPDATE, 32'd11, smu_pkg::OP_INSERT, 32'h0F0F_0F0F},
                   PREDICTED, NO_RES});
      rows.insert(rows.size(),
                  {{smu_pkg::ACT_BASE, 32'd11, smu_pkg::OP_DELETE, 32'h1},
                   PREDICTED, NO_RES});
      rows.insert(rows.size(),
                  {{smu_pkg::ACT_UPDATE, 32'd11, smu_pkg::OP_REPLACE, 32'h3C3C_3C3C},
                   PREDICTED, NO_RES});
      // closing part: entered with both slots empty and no stream ended
      rows.insert(rows.size(),
                  {{smu_pkg::ACT_BASE, 32'd100, smu_pkg::OP_INVALID, 32'h1111_1111},
                   TYPED, idle_res(1'b0, 1'b1, smu_pkg::ERR_NONE, 1'b0)});
      rows.insert(rows.size(),
                  {{smu_pkg::ACT_BASE_END, 32'h0, smu_pkg::OP_INVALID, 32'h0},
                   TYPED, idle_res(1'b0, 1'b1, smu_pkg::ERR_NONE, 1'b0)});
      rows.insert(rows.size(),
                  {{smu_pkg::ACT_BASE_END, 32'h0, smu_pkg::OP_INVALID, 32'h0},
                   TYPED, idle_res(1'b0, 1'b1, smu_pkg::ERR_REFUSED, 1'b0)});
      rows.insert(rows.size(),
                  {{smu_pkg::ACT_BASE, 32'd200, smu_pkg::OP_INSERT, 32'h4444_4444},
                   TYPED, idle_res(1'b0, 1'b1, smu_pkg::ERR_REFUSED, 1'b0)});
      rows.insert(rows.size(),
                  {{smu_pkg::ACT_UPDATE, 32'd50, smu_pkg::OP_INSERT, 32'h2222_2222},
                   TYPED, emit_res(smu_pkg::SRC_UPDATE, 32'd50, 32'h2222_2222,
                                   1'b0, 1'b1)});
      rows.insert(rows.size(),
                  {{smu_pkg::ACT_UPDATE, 32'd200, smu_pkg::OP_INVALID, 32'h3333_3333},
                   TYPED, emit_res(smu_pkg::SRC_BASE, 32'd100, 32'h1111_1111,
                                   1'b0, 1'b0)});
      rows.insert(rows.size(),
                  {{smu_pkg::ACT_BASE, 32'h0, smu_pkg::OP_DELETE, 32'h0},
                   TYPED, idle_res(1'b0, 1'b1, smu_pkg::ERR_REFUSED, 1'b0)});
      rows.insert(rows.size(),
                  {{smu_pkg::ACT_UPDATE, 32'd300, smu_pkg::OP_DELETE, 32'h5555_5555},
                   PREDICTED, NO_RES});
      rows.insert(rows.size(),
                  {{smu_pkg::ACT_UPDATE, 32'hFFFF_FFFF, smu_pkg::OP_REPLACE, 32'hFFFF_FFFF},
                   PREDICTED, NO_RES});
      rows.insert(rows.size(),
                  {{smu_pkg::ACT_UPDATE, 32'h0, smu_pkg::OP_INSERT, 32'h0},
                   PREDICTED, NO_RES});
      rows.insert(rows.size(),
                  {{smu_pkg::ACT_UPD_END, 32'hFFFF_FFFF, smu_pkg::OP_DELETE, 32'hFFFF_FFFF},
                   TYPED, idle_res(1'b0, 1'b0, smu_pkg::ERR_NONE, 1'b1)});
      rows.insert(rows.size(),
                  {{smu_pkg::ACT_UPD_END, 32'h0, smu_pkg::OP_INVALID, 32'h0},
                   TYPED, idle_res(1'b0, 1'b0, smu_pkg::ERR_REFUSED, 1'b1)});
      rows.insert(rows.size(),
                  {{smu_pkg::ACT_UPDATE, 32'd5, smu_pkg::OP_INSERT, 32'h6},
                   TYPED, idle_res(1'b0, 1'b0, smu_pkg::ERR_REFUSED, 1'b1)});

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < OPENING_ROWS; i++)
         send_item(rows[i].stim, rows[i].fixed, rows[i].want);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         idle_pct = (i >= CALM_FIRST && i < CALM_LAST) ? 0 : IDLE_PCT;
         send_item(next_record(), PREDICTED, NO_RES);
      end

      // empty both slots so the closing rows start from a known state
      while (base_held || upd_held) begin
         it.rec_payload = $urandom;
         if (base_held) begin
            it.action    = smu_pkg::ACT_UPDATE;
            it.rec_key   = base_key;
            it.update_op = smu_pkg::OP_DELETE;
         end else begin
            it.action    = smu_pkg::ACT_BASE;
            it.rec_key   = upd_key;
            it.update_op = 2'($urandom_range(0, 3));
         end
         send_item(it, PREDICTED, NO_RES);
      end

      for (int i = OPENING_ROWS; i < rows.size(); i++)
         send_item(rows[i].stim, rows[i].fixed, rows[i].want);
      req_valid = 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(0, 99) >= idle_pct);
   end

   always @(posedge clock) begin : check_results
      smu_pkg::result_type got;
      smu_pkg::result_type exp;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_emit_valid, rsp_emit_source, rsp_out_key, rsp_out_payload,
                rsp_want_base, rsp_want_update, rsp_error_code, rsp_done_res};
         if (pending_results.size() == 0) begin
            note_failure("response with no transaction outstanding");
         end else begin
            exp = pending_results.pop_front();
            check_field("emit_valid", 32'(got.emit_valid), 32'(exp.emit_valid));
            check_field("emit_source", 32'(got.emit_source), 32'(exp.emit_source));
            check_field("out_key", got.out_key, exp.out_key);
            check_field("out_payload", got.out_payload, exp.out_payload);
            check_field("want_base", 32'(got.want_base), 32'(exp.want_base));
            check_field("want_update", 32'(got.want_update), 32'(exp.want_update));
            check_field("error_code", 32'(got.error_code), 32'(exp.error_code));
            check_field("done_res", 32'(got.done_res), 32'(exp.done_res));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ERROR: cycle limit reached, %0d responses outstanding",
                  pending_results.size());
         $display("Test completed with failures");
         $finish;
      end
   end

endmodule

// ===== sim.f =====
sv/smu_pkg.sv
sv/smu_merge_core.sv
sv/smu_out_queue.sv
sv/sorted_merge_update_unit.sv
sv/smu_checker.sv
verif/sorted_merge_update_unit_test.sv
